@@ rtl/svs_pkg.sv @@
`default_nettype none
package svs_pkg;

  typedef enum logic [3:0] {
    ST_OK,
    ST_NC_FROM_OK,
    ST_CR_FROM_LESS,
    ST_NR_FROM_LESS,
    ST_NC_FROM_MORE,
    ST_CR_FROM_NR,
    ST_NR,
    ST_MONITOR,
    ST_INFO
  } status_e;

  localparam logic [2:0] LVL_OK      = 3'd0;
  localparam logic [2:0] LVL_NC      = 3'd1;
  localparam logic [2:0] LVL_CR      = 3'd2;
  localparam logic [2:0] LVL_NR      = 3'd3;
  localparam logic [2:0] LVL_MONITOR = 3'd4;
  localparam logic [2:0] LVL_INFO    = 3'd5;

  localparam logic FUNC_TRANSITION = 1'b0;
  localparam logic FUNC_REARM      = 1'b1;

  localparam logic CFG_EVENTS_DISABLED   = 1'b0;
  localparam logic CFG_SCANNING_DISABLED = 1'b1;

  localparam logic [1:0] LEN_NONE       = 2'd0;
  localparam logic [1:0] LEN_REARM      = 2'd1;
  localparam logic [1:0] LEN_TRANSITION = 2'd3;

  localparam logic [7:0] EVT_ASSERT_BASE = 8'h40;
  localparam logic [7:0] FLAG_EVENTS     = 8'h80;
  localparam logic [7:0] FLAG_SCANNING   = 8'h40;
  localparam logic [7:0] FLAG_NONE       = 8'h00;

  typedef struct packed {
    logic       event_fire;
    logic [7:0] event_first_byte;
    logic [3:0] event_prev_status;
    logic [1:0] event_length;
    logic [3:0] status_code;
    logic [2:0] raw_severity;
    logic [8:0] event_state_mask;
    logic [7:0] reading_flags;
    logic       level_error;
  } result_t;

  function automatic status_e next_status(logic [2:0] lvl, status_e old);
    status_e nw;
    nw = ST_INFO;
    unique case (lvl)
      LVL_OK: nw = ST_OK;
      LVL_NC: begin
        unique case (old)
          ST_OK, ST_NC_FROM_OK, ST_MONITOR, ST_INFO: nw = ST_NC_FROM_OK;
          default: nw = ST_NC_FROM_MORE;
        endcase
      end
      LVL_CR: begin
        unique case (old)
          ST_NR_FROM_LESS, ST_CR_FROM_NR, ST_NR: nw = ST_CR_FROM_NR;
          default: nw = ST_CR_FROM_LESS;
        endcase
      end
      LVL_NR: begin
        unique case (old)
          ST_OK, ST_NC_FROM_OK, ST_CR_FROM_LESS, ST_NR_FROM_LESS,
          ST_NC_FROM_MORE, ST_CR_FROM_NR: nw = ST_NR_FROM_LESS;
          default: nw = ST_NR;
        endcase
      end
      LVL_MONITOR: nw = ST_MONITOR;
      default: nw = ST_INFO;
    endcase
    return nw;
  endfunction

  function automatic logic [2:0] severity_of(status_e st);
    logic [2:0] sev;
    sev = LVL_NR;
    unique case (st)
      ST_OK: sev = LVL_OK;
      ST_NC_FROM_OK, ST_NC_FROM_MORE: sev = LVL_NC;
      ST_CR_FROM_LESS, ST_CR_FROM_NR: sev = LVL_CR;
      ST_MONITOR: sev = LVL_MONITOR;
      ST_INFO: sev = LVL_INFO;
      default: sev = LVL_NR;
    endcase
    return sev;
  endfunction

endpackage
`default_nettype wire

@@ rtl/svs_eval.sv @@
`default_nettype none
module svs_eval (
  input  svs_pkg::status_e status_i,
  input  logic             func_i,
  input  logic [2:0]       level_i,
  input  logic             send_request_i,
  input  logic             events_disabled_i,
  input  logic             scanning_disabled_i,
  output svs_pkg::status_e status_d_o,
  output svs_pkg::result_t result_o
);
  import svs_pkg::*;

  status_e    nw;
  status_e    st;
  logic [8:0] mask;

  always_comb begin
    nw         = next_status(level_i, status_i);
    st         = status_i;
    result_o   = '0;
    if (func_i == FUNC_REARM) begin
      result_o.event_fire       = 1'b1;
      result_o.event_first_byte = {4'd0, status_i};
      result_o.event_length     = LEN_REARM;
    end else if (level_i > LVL_INFO) begin
      result_o.level_error = 1'b1;
    end else begin
      st = nw;
      if (send_request_i && (nw != status_i)) begin
        result_o.event_fire        = 1'b1;
        result_o.event_first_byte  = EVT_ASSERT_BASE | {4'd0, nw};
        result_o.event_prev_status = status_i;
        result_o.event_length      = LEN_TRANSITION;
      end
    end
    mask = '0;
    if (st <= ST_INFO) begin
      mask = 9'(1) << st;
    end
    status_d_o                = st;
    result_o.status_code      = st;
    result_o.raw_severity     = severity_of(st);
    result_o.event_state_mask = mask;
    result_o.reading_flags    = (events_disabled_i ? FLAG_NONE : FLAG_EVENTS)
                              | (scanning_disabled_i ? FLAG_NONE : FLAG_SCANNING);
  end

endmodule
`default_nettype wire

@@ rtl/severity_sensor_fsm.sv @@
// Pipeline: a request is captured in the input register when accepted, then
// evaluated and written to the result register when the output can advance.
// Throughput: one request per cycle unless the output stalls; an input register
// and a result register with the status update in between set that figure.
// Reset: asynchronous, active low; status returns to transition to OK, both
// disable registers to zero, and both pipeline stages empty.
`default_nettype none
module severity_sensor_fsm (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [2:0] level_i,
  input  logic       send_request_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       event_fire_o,
  output logic [7:0] event_first_byte_o,
  output logic [3:0] event_prev_status_o,
  output logic [1:0] event_length_o,
  output logic [3:0] status_code_o,
  output logic [2:0] raw_severity_o,
  output logic [8:0] event_state_mask_o,
  output logic [7:0] reading_flags_o,
  output logic       level_error_o
);
  import svs_pkg::*;

  logic       events_disabled_q, scanning_disabled_q;
  status_e    status_q, status_d;
  logic       s1_valid_q, s1_valid_d;
  logic       s1_func_q;
  logic [2:0] s1_level_q;
  logic       s1_send_q;
  logic       out_valid_q, out_valid_d;
  result_t    result_q, result_d;
  logic       advance, accept, move;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign move       = s1_valid_q && advance;

  assign s1_valid_d  = accept ? 1'b1 : (move ? 1'b0 : s1_valid_q);
  assign out_valid_d = move ? 1'b1 : (out_valid_q && out_stall_i);

  svs_eval u_eval (
    .status_i            (status_q),
    .func_i              (s1_func_q),
    .level_i             (s1_level_q),
    .send_request_i      (s1_send_q),
    .events_disabled_i   (events_disabled_q),
    .scanning_disabled_i (scanning_disabled_q),
    .status_d_o          (status_d),
    .result_o            (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      events_disabled_q   <= 1'b0;
      scanning_disabled_q <= 1'b0;
      status_q            <= ST_OK;
      s1_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_EVENTS_DISABLED:   events_disabled_q   <= cfg_wdata_i;
          CFG_SCANNING_DISABLED: scanning_disabled_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (move) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q  <= func_i;
      s1_level_q <= level_i;
      s1_send_q  <= send_request_i;
    end
    if (move) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign event_fire_o        = result_q.event_fire;
  assign event_first_byte_o  = result_q.event_first_byte;
  assign event_prev_status_o = result_q.event_prev_status;
  assign event_length_o      = result_q.event_length;
  assign status_code_o       = result_q.status_code;
  assign raw_severity_o      = result_q.raw_severity;
  assign event_state_mask_o  = result_q.event_state_mask;
  assign reading_flags_o     = result_q.reading_flags;
  assign level_error_o       = result_q.level_error;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked pipeline");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(event_state_mask_o))
    else $error("event state mask is not one-hot");

  a_error_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && level_error_o) |-> (!event_fire_o && event_length_o == LEN_NONE))
    else $error("event raised for an invalid level");

  a_status_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> (out_valid_o && status_code_o == status_q))
    else $error("delivered status differs from held status");

endmodule
`default_nettype wire
